// ----- sv/znpr_pkg.sv -----
// ----------------------------------------------------------------------------
// znpr_pkg
// Shared types and opcode constants for the Z80 next-PC resolver.
// ----------------------------------------------------------------------------
package znpr_pkg;

  localparam int unsigned InTdataW  = 128;
  localparam int unsigned OutTdataW = 24;

  // Opcodes and masks
  localparam logic [7:0] OpJpNn     = 8'hC3;
  localparam logic [7:0] OpCallNn   = 8'hCD;
  localparam logic [7:0] MaskCc     = 8'hC7;
  localparam logic [7:0] OpJpCc     = 8'hC2;
  localparam logic [7:0] OpCallCc   = 8'hC4;
  localparam logic [7:0] OpRetCc    = 8'hC0;
  localparam logic [7:0] OpRst      = 8'hC7;
  localparam logic [7:0] OpRst30    = 8'hF7;
  localparam logic [7:0] OpRst38    = 8'hFF;
  localparam logic [7:0] MaskRstVec = 8'h38;
  localparam logic [7:0] OpJpHl     = 8'hE9;
  localparam logic [7:0] PfxIx      = 8'hDD;
  localparam logic [7:0] PfxIy      = 8'hFD;
  localparam logic [7:0] PfxEd      = 8'hED;
  localparam logic [7:0] OpRet      = 8'hC9;
  localparam logic [7:0] OpReti     = 8'h4D;
  localparam logic [7:0] OpRetn     = 8'h45;
  localparam logic [7:0] OpJr       = 8'h18;
  localparam logic [7:0] OpJrC      = 8'h38;
  localparam logic [7:0] OpJrNc     = 8'h30;
  localparam logic [7:0] OpJrZ      = 8'h28;
  localparam logic [7:0] OpJrNz     = 8'h20;
  localparam logic [7:0] OpDjnz     = 8'h10;
  localparam logic [7:0] BregOne    = 8'h01;

  // Flag bit positions in F
  localparam int unsigned FlgS = 7;
  localparam int unsigned FlgZ = 6;
  localparam int unsigned FlgP = 2;
  localparam int unsigned FlgC = 0;

  // Condition codes, opcode bits 5..3
  typedef enum logic [2:0] {
    CC_NZ = 3'd0,
    CC_Z  = 3'd1,
    CC_NC = 3'd2,
    CC_C  = 3'd3,
    CC_PO = 3'd4,
    CC_PE = 3'd5,
    CC_P  = 3'd6,
    CC_M  = 3'd7
  } cc_t;

  typedef struct packed {
    logic [15:0] pc_now;
    logic [7:0]  opcode_first;
    logic [7:0]  opcode_second;
    logic [7:0]  opcode_third;
    logic [2:0]  instr_length;
    logic [7:0]  flag_byte;
    logic [7:0]  reg_b_value;
    logic [15:0] hl_value;
    logic [15:0] ix_value;
    logic [15:0] iy_value;
    logic [15:0] stack_word;
  } item_t;

  typedef struct packed {
    logic [15:0] next_addr;
    logic        transfer_taken;
  } result_t;

  function automatic logic cond_holds(input logic [7:0] op, input logic [7:0] f);
    logic r;
    unique case (cc_t'(op[5:3]))
      CC_NZ:   r = ~f[FlgZ];
      CC_Z:    r =  f[FlgZ];
      CC_NC:   r = ~f[FlgC];
      CC_C:    r =  f[FlgC];
      CC_PO:   r = ~f[FlgP];
      CC_PE:   r =  f[FlgP];
      CC_P:    r = ~f[FlgS];
      CC_M:    r =  f[FlgS];
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/znpr_decode.sv -----
// ----------------------------------------------------------------------------
// znpr_decode
// Combinational branch decode: picks the next instruction address.
// ----------------------------------------------------------------------------
module znpr_decode (
  input  znpr_pkg::item_t   item,
  output znpr_pkg::result_t res
);
  import znpr_pkg::*;

  logic [15:0] seq;
  logic [15:0] nn;
  logic [15:0] disp;
  logic [7:0]  op;
  logic [7:0]  b1;
  logic        cc_ok;
  logic        rel;

  assign op    = item.opcode_first;
  assign b1    = item.opcode_second;
  assign seq   = item.pc_now + {13'd0, item.instr_length};
  assign nn    = {item.opcode_third, b1};
  assign disp  = {{8{b1[7]}}, b1};
  assign cc_ok = cond_holds(op, item.flag_byte);

  always_comb begin
    res.next_addr      = seq;
    res.transfer_taken = 1'b0;
    rel                = 1'b0;
    if (op == OpJpNn || op == OpCallNn) begin
      res.next_addr      = nn;
      res.transfer_taken = 1'b1;
    end else if ((op & MaskCc) == OpJpCc || (op & MaskCc) == OpCallCc) begin
      if (cc_ok) begin
        res.next_addr      = nn;
        res.transfer_taken = 1'b1;
      end
    end else if (op == OpJpHl) begin
      res.next_addr      = item.hl_value;
      res.transfer_taken = 1'b1;
    end else if (op == PfxIx && b1 == OpJpHl) begin
      res.next_addr      = item.ix_value;
      res.transfer_taken = 1'b1;
    end else if (op == PfxIy && b1 == OpJpHl) begin
      res.next_addr      = item.iy_value;
      res.transfer_taken = 1'b1;
    end else if (op == OpRet || (op == PfxEd && (b1 == OpReti || b1 == OpRetn))) begin
      res.next_addr      = item.stack_word;
      res.transfer_taken = 1'b1;
    end else if ((op & MaskCc) == OpRetCc) begin
      if (cc_ok) begin
        res.next_addr      = item.stack_word;
        res.transfer_taken = 1'b1;
      end
    end else if (op == OpJr) begin
      rel = 1'b1;
    end else if (op == OpJrC) begin
      rel = item.flag_byte[FlgC];
    end else if (op == OpJrNc) begin
      rel = ~item.flag_byte[FlgC];
    end else if (op == OpJrZ) begin
      rel = item.flag_byte[FlgZ];
    end else if (op == OpJrNz) begin
      rel = ~item.flag_byte[FlgZ];
    end else if (op == OpDjnz) begin
      rel = (item.reg_b_value != BregOne);
    end else if ((op & MaskCc) == OpRst && op != OpRst30 && op != OpRst38) begin
      res.next_addr      = {8'd0, op & MaskRstVec};
      res.transfer_taken = 1'b1;
    end

    // relative jumps add the sign-extended displacement to the fall-through address
    if (rel) begin
      res.next_addr      = seq + disp;
      res.transfer_taken = 1'b1;
    end
  end

endmodule

// ----- sv/z80_next_pc_resolver.sv -----
// ----------------------------------------------------------------------------
// z80_next_pc_resolver
// Resolves the address of the next Z80 instruction from the current one.
// ----------------------------------------------------------------------------
// One instruction transaction in, one result transaction out. The block takes
// a new instruction every cycle unless backpressure holds the pipeline; an
// accepted instruction passes through the input register, then the decode
// and the 16-bit address add, then the result register. Jumps, calls,
// returns (including RETI/RETN), JR, DJNZ (taken when B is not 1) and RST
// (except 30h and 38h) are resolved; everything else continues at
// pc_now + instr_length. All addresses wrap modulo 65536. Backpressure on the
// result side stalls the pipeline stage by stage; no transaction is lost.
module z80_next_pc_resolver (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata from bit 0: pc_now[15:0], opcode_first[7:0], opcode_second[7:0],
  // opcode_third[7:0], instr_length[2:0], flag_byte[7:0], reg_b_value[7:0],
  // hl_value[15:0], ix_value[15:0], iy_value[15:0], stack_word[15:0], zero fill
  input  logic [znpr_pkg::InTdataW-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata from bit 0: next_addr[15:0], transfer_taken, zero fill
  output logic [znpr_pkg::OutTdataW-1:0]   out_tdata
);
  import znpr_pkg::*;

  item_t   in_item;
  item_t   item_r;
  item_t   item_nxt;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  result_t dec_res;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    s2_adv;
  logic    s1_adv;

  // Unpack the bus into fields
  always_comb begin
    in_item.pc_now        = in_tdata[15:0];
    in_item.opcode_first  = in_tdata[23:16];
    in_item.opcode_second = in_tdata[31:24];
    in_item.opcode_third  = in_tdata[39:32];
    in_item.instr_length  = in_tdata[42:40];
    in_item.flag_byte     = in_tdata[50:43];
    in_item.reg_b_value   = in_tdata[58:51];
    in_item.hl_value      = in_tdata[74:59];
    in_item.ix_value      = in_tdata[90:75];
    in_item.iy_value      = in_tdata[106:91];
    in_item.stack_word    = in_tdata[122:107];
  end

  // Result register moves when empty or when its content is taken
  assign s2_adv    = ~out_valid_r | out_tready;
  // Input register moves when empty or when it can pass to the result stage
  assign s1_adv    = ~s1_valid_r | s2_adv;
  assign in_tready = s1_adv;

  // Stage 1: capture the accepted instruction
  always_comb begin
    item_nxt     = item_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = in_tvalid;
      if (in_tvalid) begin
        item_nxt = in_item;
      end
    end
  end

  znpr_decode u_decode (
    .item (item_r),
    .res  (dec_res)
  );

  // Stage 2: hold the resolved address until the sink takes it
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (s2_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        res_nxt = dec_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.transfer_taken, res_r.next_addr};

endmodule

// ----- test/tb_z80_next_pc_resolver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_z80_next_pc_resolver
// Self-checking testbench for the Z80 next-PC resolver.
// ----------------------------------------------------------------------------
// Instructions are driven into the input stream and the expected next address
// and taken flag are computed by a local decoder at the moment of acceptance.
// A monitor pops the oldest expectation for every result transaction and
// compares both fields. Directed cases cover the field extremes and each
// control-transfer family. Random instructions with full-range register
// content follow. Both sides idle at random, and one phase holds the result
// side off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_z80_next_pc_resolver;
  import znpr_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // tdata from bit 0: pc_now, opcode_first, opcode_second, opcode_third,
  // instr_length, flag_byte, reg_b_value, hl_value, ix_value, iy_value,
  // stack_word, zero fill
  logic [InTdataW-1:0]  in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  // tdata from bit 0: next_addr, transfer_taken, zero fill
  logic [OutTdataW-1:0] out_tdata;

  // Expected results, oldest first
  result_t pending_targets[$];
  result_t got_target;
  result_t want_target;

  int unsigned instrs_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned taken_seen     = 0;
  int unsigned fallthru_seen  = 0;

  // Idling controls shared by the sender and the receiver process
  bit          src_idle  = 1'b0;
  bit          sink_idle = 1'b0;
  int unsigned hold_req  = 0;

  z80_next_pc_resolver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decoder used for prediction
  // --------------------------------------------------------------------------

  // Evaluate the condition code held in opcode bits 5..3 against F
  function automatic logic cc_met(input logic [7:0] op, input logic [7:0] f);
    logic met;
    case (cc_t'(op[5:3]))
      CC_NZ:   met = !f[FlgZ];
      CC_Z:    met =  f[FlgZ];
      CC_NC:   met = !f[FlgC];
      CC_C:    met =  f[FlgC];
      CC_PO:   met = !f[FlgP];
      CC_PE:   met =  f[FlgP];
      CC_P:    met = !f[FlgS];
      default: met =  f[FlgS];
    endcase
    return met;
  endfunction

  // Work out where execution continues after one instruction
  function automatic result_t resolve_next_pc(input item_t it);
    logic [7:0]  op;
    logic [7:0]  b1;
    logic [15:0] seq;
    logic [15:0] nn;
    logic [15:0] disp;
    logic [15:0] addr;
    logic        taken;
    logic        rel;
    result_t     r;
    op    = it.opcode_first;
    b1    = it.opcode_second;
    seq   = it.pc_now + {13'd0, it.instr_length};
    nn    = {it.opcode_third, b1};
    disp  = {{8{b1[7]}}, b1};
    addr  = seq;
    taken = 1'b0;
    rel   = 1'b0;
    if (op == OpJpNn || op == OpCallNn) begin
      addr  = nn;
      taken = 1'b1;
    end else if ((op & MaskCc) == OpJpCc || (op & MaskCc) == OpCallCc) begin
      if (cc_met(op, it.flag_byte)) begin
        addr  = nn;
        taken = 1'b1;
      end
    end else if (op == OpJpHl) begin
      addr  = it.hl_value;
      taken = 1'b1;
    end else if (op == PfxIx && b1 == OpJpHl) begin
      addr  = it.ix_value;
      taken = 1'b1;
    end else if (op == PfxIy && b1 == OpJpHl) begin
      addr  = it.iy_value;
      taken = 1'b1;
    end else if (op == OpRet || (op == PfxEd && (b1 == OpReti || b1 == OpRetn))) begin
      addr  = it.stack_word;
      taken = 1'b1;
    end else if ((op & MaskCc) == OpRetCc) begin
      if (cc_met(op, it.flag_byte)) begin
        addr  = it.stack_word;
        taken = 1'b1;
      end
    end else if (op == OpJr) begin
      rel = 1'b1;
    end else if (op == OpJrC) begin
      rel = it.flag_byte[FlgC];
    end else if (op == OpJrNc) begin
      rel = !it.flag_byte[FlgC];
    end else if (op == OpJrZ) begin
      rel = it.flag_byte[FlgZ];
    end else if (op == OpJrNz) begin
      rel = !it.flag_byte[FlgZ];
    end else if (op == OpDjnz) begin
      rel = (it.reg_b_value != BregOne);
    end else if ((op & MaskCc) == OpRst && op != OpRst30 && op != OpRst38) begin
      addr  = {8'h00, op & MaskRstVec};
      taken = 1'b1;
    end
    if (rel) begin
      addr  = seq + disp;
      taken = 1'b1;
    end
    r.next_addr      = addr;
    r.transfer_taken = taken;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] with_cc(input logic [7:0] base, input cc_t cc);
    return base | {2'b00, cc, 3'b000};
  endfunction

  // Instruction with the given bytes and random register content
  function automatic item_t make_instr(input logic [7:0] op, input logic [7:0] b1,
                                       input logic [7:0] b2);
    item_t it;
    it.pc_now        = 16'($urandom);
    it.opcode_first  = op;
    it.opcode_second = b1;
    it.opcode_third  = b2;
    it.instr_length  = 3'($urandom_range(1, 4));
    it.flag_byte     = 8'($urandom);
    it.reg_b_value   = 8'($urandom);
    it.hl_value      = 16'($urandom);
    it.ix_value      = 16'($urandom);
    it.iy_value      = 16'($urandom);
    it.stack_word    = 16'($urandom);
    return it;
  endfunction

  // Send one instruction. Enter and leave at a falling edge; tvalid stays
  // high on exit so that transactions can follow back to back.
  task automatic send_instr(input item_t it);
    int unsigned gap;
    gap = (src_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {5'd0, it.stack_word, it.iy_value, it.ix_value, it.hl_value,
                 it.reg_b_value, it.flag_byte, it.instr_length, it.opcode_third,
                 it.opcode_second, it.opcode_first, it.pc_now};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_targets.push_back(resolve_next_pc(it));
    instrs_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All-zero and all-one items, address wrap, lengths outside 1..4
  task automatic test_field_extremes();
    item_t it;
    it = '0;
    send_instr(it);
    it = '1;
    send_instr(it);
    it = make_instr(8'h00, 8'h00, 8'h00);
    it.pc_now       = 16'hFFFF;
    it.instr_length = 3'd4;
    send_instr(it);
    it = make_instr(OpJr, 8'h7F, 8'h00);
    it.pc_now       = 16'hFFFE;
    it.instr_length = 3'd7;
    send_instr(it);
    stop_sending();
  endtask

  task automatic test_jumps_and_calls();
    item_t it;
    send_instr(make_instr(OpJpNn, 8'h34, 8'h12));
    send_instr(make_instr(OpCallNn, 8'hFF, 8'hFF));
    it = make_instr(with_cc(OpJpCc, CC_NZ), 8'h00, 8'h80);
    it.flag_byte[FlgZ] = 1'b0;
    send_instr(it);
    it = make_instr(with_cc(OpJpCc, CC_Z), 8'h55, 8'hAA);
    it.flag_byte[FlgZ] = 1'b0;
    send_instr(it);
    it = make_instr(with_cc(OpCallCc, CC_M), 8'h01, 8'h00);
    it.flag_byte[FlgS] = 1'b1;
    send_instr(it);
    send_instr(make_instr(OpJpHl, 8'h00, 8'h00));
    send_instr(make_instr(PfxIx, OpJpHl, 8'h00));
    send_instr(make_instr(PfxIy, OpJpHl, 8'h00));
    // Prefix without the jump opcode behind it falls through
    send_instr(make_instr(PfxIx, 8'h21, 8'h00));
    stop_sending();
  endtask

  task automatic test_returns();
    item_t it;
    send_instr(make_instr(OpRet, 8'h00, 8'h00));
    send_instr(make_instr(PfxEd, OpReti, 8'h00));
    send_instr(make_instr(PfxEd, OpRetn, 8'h00));
    send_instr(make_instr(PfxEd, 8'h44, 8'h00));
    it = make_instr(with_cc(OpRetCc, CC_PE), 8'h00, 8'h00);
    it.flag_byte[FlgP] = 1'b0;
    send_instr(it);
    stop_sending();
  endtask

  task automatic test_relative_jumps();
    item_t it;
    send_instr(make_instr(OpJr, 8'h80, 8'h00));
    it = make_instr(OpJrC, 8'hFE, 8'h00);
    it.flag_byte[FlgC] = 1'b1;
    send_instr(it);
    it = make_instr(OpJrNc, 8'h10, 8'h00);
    it.flag_byte[FlgC] = 1'b1;
    send_instr(it);
    // DJNZ falls through only when B is 1; B of 0 wraps and loops
    it = make_instr(OpDjnz, 8'hF0, 8'h00);
    it.reg_b_value = BregOne;
    send_instr(it);
    it = make_instr(OpDjnz, 8'hF0, 8'h00);
    it.reg_b_value = 8'h00;
    send_instr(it);
    stop_sending();
  endtask

  // RST 30h and 38h fall through, the others vector
  task automatic test_restarts();
    send_instr(make_instr(OpRst, 8'h00, 8'h00));
    send_instr(make_instr(with_cc(OpRst, CC_PE), 8'h00, 8'h00));
    send_instr(make_instr(OpRst30, 8'h00, 8'h00));
    stop_sending();
  endtask

  // Mostly control-transfer opcodes with random content, the rest any byte
  task automatic test_random_mix(input int unsigned count, input bit src_gaps,
                                 input bit sink_stalls);
    item_t       it;
    logic [7:0]  op;
    logic [7:0]  b1;
    src_idle  = src_gaps;
    sink_idle = sink_stalls;
    repeat (count) begin
      case ($urandom_range(0, 16))
        0:       op = OpJpNn;
        1:       op = OpCallNn;
        2:       op = with_cc(OpJpCc, cc_t'($urandom_range(0, 7)));
        3:       op = with_cc(OpCallCc, cc_t'($urandom_range(0, 7)));
        4:       op = OpJpHl;
        5:       op = PfxIx;
        6:       op = PfxIy;
        7:       op = PfxEd;
        8:       op = OpRet;
        9:       op = with_cc(OpRetCc, cc_t'($urandom_range(0, 7)));
        10: begin
          case ($urandom_range(0, 4))
            0:       op = OpJr;
            1:       op = OpJrC;
            2:       op = OpJrNc;
            3:       op = OpJrZ;
            default: op = OpJrNz;
          endcase
        end
        11:      op = OpDjnz;
        12:      op = with_cc(OpRst, cc_t'($urandom_range(0, 7)));
        default: op = 8'($urandom);
      endcase
      b1 = 8'($urandom);
      if ((op == PfxIx || op == PfxIy || op == PfxEd) && $urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 2))
          0:       b1 = OpJpHl;
          1:       b1 = OpReti;
          default: b1 = OpRetn;
        endcase
      end
      it = make_instr(op, b1, 8'($urandom));
      if ($urandom_range(0, 99) < 15) it.instr_length = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       it.reg_b_value = BregOne;
        1:       it.reg_b_value = 8'h00;
        2:       it.reg_b_value = 8'hFF;
        default: ;
      endcase
      send_instr(it);
    end
    stop_sending();
  endtask

  // Hold the result side off while instructions keep coming, so the
  // pipeline fills and in_tready drops
  task automatic test_output_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 150;
    repeat (30) send_instr(make_instr(OpJr, 8'($urandom), 8'($urandom)));
    stop_sending();
  endtask

  // --------------------------------------------------------------------------
  // Result side: drive out_tready at the falling edge
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        out_tready = 1'b0;
        hold_req--;
      end else if (stall_left != 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (sink_idle && $urandom_range(0, 99) < 20) begin
        stall_left = idle_len() - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check at the rising edge: compare against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_target.next_addr      = out_tdata[15:0];
      got_target.transfer_taken = out_tdata[16];
      if (pending_targets.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: next_addr=%h taken=%b", $realtime,
                   got_target.next_addr, got_target.transfer_taken);
      end else begin
        want_target = pending_targets.pop_front();
        results_checked++;
        if (want_target.transfer_taken) taken_seen++;
        else fallthru_seen++;
        if (got_target.next_addr != want_target.next_addr ||
            got_target.transfer_taken != want_target.transfer_taken) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: next_addr exp %h got %h, taken exp %b got %b",
                     $realtime, want_target.next_addr, got_target.next_addr,
                     want_target.transfer_taken, got_target.transfer_taken);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_jumps_and_calls();
    test_returns();
    test_relative_jumps();
    test_restarts();
    test_random_mix(1100, 1'b1, 1'b1);
    test_output_backpressure();
    // Stretch with no idling on either side
    test_random_mix(350, 1'b0, 1'b0);
    test_random_mix(300, 1'b1, 1'b0);

    // Drain, then allow for the two-stage pipeline
    sink_idle = 1'b0;
    while (pending_targets.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);

    if (pending_targets.size() != 0) mismatch_count++;
    $display("Sent %0d instructions, checked %0d results (%0d taken, %0d fall through).",
             instrs_sent, results_checked, taken_seen, fallthru_seen);
    $display("Mismatched or unexpected results: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/znpr_pkg.sv
sv/znpr_decode.sv
sv/z80_next_pc_resolver.sv
test/tb_z80_next_pc_resolver.sv
